### design/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_e;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] ANY_CHAR   = 8'h3F;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Decoded item as it sits in the queue between front and back.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;       // case-folded byte
    logic       is_star;
    logic       is_any;
  } item_t;

endpackage

### design/wildcard_glob_matcher_unit.sv
// An end-of-subject result passes the queue, then the result register. Throughput: one item
// per cycle unless the queue is full; the position-set update covers all pattern positions
// at once, and a two-entry queue plus the result register absorb output stalls.
// Reset (rst_ni low, asynchronous): pattern empty, overflow cleared, queue and result
// register empty. No clearing pass; pattern bytes are only read below the stored length.
// Top level of the wildcard glob matcher.
module wildcard_glob_matcher_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);
  import wgm_pkg::*;

  item_t front_item, back_item;
  logic  push, full, q_valid, pop;

  wgm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .character_i (character_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  wgm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (back_item)
  );

  wgm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (q_valid),
    .item_i             (back_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

endmodule

### design/wgm_front.sv
// Front end: input handshake, opcode decode and case folding.
module wgm_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     operation_i,
  input  logic [7:0]     character_i,
  input  logic           full_i,
  output logic           push_o,
  output wgm_pkg::item_t item_o
);
  import wgm_pkg::*;

  logic is_upper;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign is_upper   = (character_i >= UPPER_A) && (character_i <= UPPER_Z);

  always_comb begin
    item_o.op      = op_e'(operation_i);
    item_o.ch      = is_upper ? (character_i + CASE_DELTA) : character_i;
    item_o.is_star = (character_i == STAR_CHAR);
    item_o.is_any  = (character_i == ANY_CHAR);
  end

endmodule

### design/wgm_queue.sv
// Two-entry queue of decoded items between front and back.
module wgm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wgm_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output wgm_pkg::item_t item_o
);
  import wgm_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### design/wgm_back.sv
// Back end: pattern store, active-position set update and result register.
module wgm_back #(
  parameter int PATTERN_MAX = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  wgm_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           matched_o,
  output logic           pattern_overflow_o
);
  import wgm_pkg::*;

  localparam int P    = PATTERN_MAX + 1;
  localparam int LenW = $clog2(PATTERN_MAX + 1);

  logic [7:0]             pat_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_q, any_q;
  logic [PATTERN_MAX-1:0] used_q, used_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [P-1:0]           act_q, act_d;
  logic [P-1:0]           init_q, init_d;
  logic                   ovf_q, ovf_d;
  logic                   out_valid_q, out_valid_d;
  logic                   matched_q, ovf_out_q;

  logic                   room;
  logic                   do_append;
  logic [PATTERN_MAX-1:0] live, hit, stay, adv;
  logic [P-1:0]           gen, prop;
  logic [P-1:0]           closed;

  assign room      = (len_q < LenW'(PATTERN_MAX));
  assign pop_o     = valid_i && ((item_i.op != OP_END) || !out_valid_q || !out_stall_i);
  assign do_append = pop_o && (item_i.op == OP_APPEND) && room;

  // One lane per pattern position, then a log-depth prefix for star runs.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i] = any_q[i] || (pat_q[i] == item_i.ch);
    end
    live = act_q[PATTERN_MAX-1:0] & used_q;
    stay = live & star_q;
    adv  = live & ~star_q & hit;
    gen  = {1'b0, stay} | {adv, 1'b0};
    prop = {star_q & used_q, 1'b0};
    for (int d = 1; d < P; d = d * 2) begin
      gen  = gen | (prop & (gen << d));
      prop = prop & (prop << d);
    end
    closed = gen;
  end

  always_comb begin
    len_d       = len_q;
    used_d      = used_q;
    init_d      = init_q;
    act_d       = act_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      unique case (item_i.op)
        OP_CLEAR: begin
          len_d  = '0;
          used_d = '0;
          init_d = P'(1);
          act_d  = P'(1);
          ovf_d  = 1'b0;
        end
        OP_APPEND: begin
          if (room) begin
            len_d  = len_q + LenW'(1);
            used_d = used_q | (PATTERN_MAX'(1) << len_q);
            init_d = init_q | (P'(init_q[len_q] && item_i.is_star) << (len_q + LenW'(1)));
          end else begin
            ovf_d = 1'b1;
          end
          act_d = init_d;
        end
        OP_SUBJECT: begin
          act_d = closed;
        end
        OP_END: begin
          act_d       = init_q;
          out_valid_d = 1'b1;
        end
        default: begin
          act_d = act_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      used_q      <= '0;
      init_q      <= P'(1);
      act_q       <= P'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      used_q      <= used_d;
      init_q      <= init_d;
      act_q       <= act_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pattern lanes and result payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (do_append && (len_q == LenW'(i))) begin
        pat_q[i]  <= item_i.ch;
        star_q[i] <= item_i.is_star;
        any_q[i]  <= item_i.is_any;
      end
    end
    if (pop_o && (item_i.op == OP_END)) begin
      matched_q <= act_q[len_q];
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule

### design/wgm_checker.sv
// Port-level checker for the wildcard glob matcher, bound to the top level.
module wgm_assert_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] operation_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o,
  input logic       pattern_overflow_o
);
  import wgm_pkg::*;

  logic [2:0] pend_q;
  logic       end_beat, out_beat;

  assign end_beat = in_valid_i && !in_stall_o && (op_e'(operation_i) == OP_END);
  assign out_beat = out_valid_o && !out_stall_i;

  // End-of-subject beats taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b0, end_beat} - {2'b0, out_beat};
    end
  end

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o)
      && $stable(pattern_overflow_o))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result beat without a pending end of subject");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more pending results than the design can hold");

  a_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled although the output was free");

endmodule

bind wildcard_glob_matcher_unit wgm_assert_checker u_wgm_assert_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .operation_i        (operation_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .matched_o          (matched_o),
  .pattern_overflow_o (pattern_overflow_o)
);
